// File: sv/huffman_table_bit_packer_assert.svh
// ----------------------------------------------------------------------------
// Huffman table bit packer assertion macros
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_TABLE_BIT_PACKER_ASSERT_SVH
`define HUFFMAN_TABLE_BIT_PACKER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define HTBP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("htbp assertion failed");
// next-cycle implication
`define HTBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("htbp assertion failed");
`else
`define HTBP_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define HTBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: sv/htbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Huffman table bit packer package
// Shared sizes, command codes and beat types.
// ----------------------------------------------------------------------------
package htbp_pkg;

    localparam int ALPHABET_SIZE = 256;
    localparam int MAX_CODE_LEN  = 64;
    localparam int TOTAL_WIDTH   = 40;

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_ENCODE = 2'd1;
    localparam logic [1:0] CMD_FLUSH  = 2'd2;

    localparam logic [3:0] FULL_BYTE = 4'd8;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  symbol;
        logic [63:0] code_bits;
        logic [6:0]  code_length;
    } t_in_item;

    typedef struct packed {
        logic [7:0]             packed_byte;
        logic [3:0]             valid_bits;
        logic [TOTAL_WIDTH-1:0] stream_bits;
        logic                   last;
    } t_out_item;

    typedef struct packed {
        logic wr;
        logic rd;
    } t_tbl_ctl;

endpackage
`default_nettype wire

// File: sv/htbp_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Huffman table bit packer code table
// Code and length memories with registered read; length valid bits reset.
// ----------------------------------------------------------------------------
module htbp_table #(
    parameter int ALPHABET_SIZE = htbp_pkg::ALPHABET_SIZE,
    parameter int MAX_CODE_LEN  = htbp_pkg::MAX_CODE_LEN
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire htbp_pkg::t_tbl_ctl                       i_ctl,
    input  wire logic [$clog2(ALPHABET_SIZE)-1:0]         i_addr,
    input  wire logic [MAX_CODE_LEN-1:0]                  i_wr_code,
    input  wire logic [$clog2(MAX_CODE_LEN+1)-1:0]        i_wr_len,
    output logic      [MAX_CODE_LEN-1:0]                  o_rd_code,
    output logic      [$clog2(MAX_CODE_LEN+1)-1:0]        o_rd_len
);

    localparam int LW = $clog2(MAX_CODE_LEN + 1);

    logic [MAX_CODE_LEN-1:0]  r_code_mem [ALPHABET_SIZE];
    logic [LW-1:0]            r_len_mem  [ALPHABET_SIZE];
    logic [ALPHABET_SIZE-1:0] r_len_vld;
    logic [MAX_CODE_LEN-1:0]  r_rd_code;
    logic [LW-1:0]            r_rd_len;
    logic                     r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_code_mem[i_addr] <= i_wr_code;
            r_len_mem[i_addr]  <= i_wr_len;
        end
        if (i_ctl.rd) begin
            r_rd_code <= r_code_mem[i_addr];
            r_rd_len  <= r_len_mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_ctl.wr) begin
                r_len_vld[i_addr] <= 1'b1;
            end
            if (i_ctl.rd) begin
                r_rd_vld <= r_len_vld[i_addr];
            end
        end
    end

    // unwritten entries read as zero length
    assign o_rd_code = r_rd_code;
    assign o_rd_len  = r_rd_vld ? r_rd_len : '0;

endmodule
`default_nettype wire

// File: sv/huffman_table_bit_packer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Huffman table bit packer
// Table-driven byte-symbol Huffman encoder packing codes MSB-first into bytes.
//
// Channel   Direction  Handshake                   Beat
// in        input      i_in_valid / o_in_stall     t_in_item (command, symbol, code)
// out       output     o_out_valid / i_out_stall   t_out_item (byte, count, total, last)
//
// One item per cycle while the output is not stalled, for load, flush and encodes
// completing at most one byte; an encode completing k bytes holds the pack stage until
// all k bytes are emitted. A beat passes the input, pack and output registers in order.
// Reset clears control state and the length valid bits.
// Output stall holds the output register and backs up through both stages.
// ----------------------------------------------------------------------------
`include "huffman_table_bit_packer_assert.svh"

module huffman_table_bit_packer #(
    parameter int ALPHABET_SIZE = htbp_pkg::ALPHABET_SIZE,
    parameter int MAX_CODE_LEN  = htbp_pkg::MAX_CODE_LEN
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire htbp_pkg::t_in_item  i_in_data,
    output logic                     o_in_stall,
    output logic                     o_out_valid,
    output htbp_pkg::t_out_item      o_out_data,
    input  wire logic                i_out_stall
);

    localparam int AW = $clog2(ALPHABET_SIZE);
    localparam int LW = $clog2(MAX_CODE_LEN + 1);
    localparam int TW = LW + 1;
    localparam int NB = (MAX_CODE_LEN + 7) / 8 + 1;
    localparam int IW = $clog2(NB);
    localparam int WW = NB * 8;
    localparam int XW = htbp_pkg::TOTAL_WIDTH;

    // input stage
    logic               r_a_vld;
    htbp_pkg::t_in_item r_a;
    logic               a_move;
    logic               a_in_range;
    logic [LW-1:0]      a_len_c;
    logic [MAX_CODE_LEN-1:0] a_code_la;
    htbp_pkg::t_tbl_ctl a_ctl;

    // pack stage
    logic               r_b_vld;
    logic [1:0]         r_b_cmd;
    logic               r_b_inr;
    logic [IW-1:0]      r_b_idx;
    logic [MAX_CODE_LEN-1:0] tbl_code;
    logic [LW-1:0]      tbl_len;
    logic [LW-1:0]      b_len_eff;
    logic               b_is_flush;
    logic               b_is_enc;
    logic               b_emit_enc;
    logic [TW-1:0]      b_t;
    logic [IW-1:0]      b_n;
    logic [NB-1:0][7:0] b_win;
    logic               b_last_byte;
    logic [IW-1:0]      b_res_idx;
    logic               b_room;
    logic               b_emit;
    logic               b_done;
    logic [XW:0]        b_sum;
    htbp_pkg::t_out_item b_res;

    // stream state
    logic [7:0]         r_pend;
    logic [2:0]         r_cnt;
    logic [XW-1:0]      r_total;
    logic [7:0]         n_pend;
    logic [2:0]         n_cnt;
    logic [XW-1:0]      n_total;

    // output register
    logic                r_out_vld;
    htbp_pkg::t_out_item r_out;

    // ------------------------------------------------------------------ input
    assign a_move     = r_a_vld && (!r_b_vld || b_done);
    assign o_in_stall = r_a_vld && !a_move;

    always_comb begin
        a_in_range = {1'b0, r_a.symbol} < 9'(ALPHABET_SIZE);
        if (r_a.code_length > 7'(MAX_CODE_LEN)) begin
            a_len_c = LW'(MAX_CODE_LEN);
        end else begin
            a_len_c = r_a.code_length[LW-1:0];
        end
        // left-align the code so low unused bits are zero
        a_code_la = r_a.code_bits[MAX_CODE_LEN-1:0] << (LW'(MAX_CODE_LEN) - a_len_c);
        a_ctl.wr  = a_move && (r_a.command == htbp_pkg::CMD_LOAD) && a_in_range;
        a_ctl.rd  = a_move;
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_a <= i_in_data;
        end
    end

    htbp_table #(
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .MAX_CODE_LEN  (MAX_CODE_LEN)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (a_ctl),
        .i_addr    (r_a.symbol[AW-1:0]),
        .i_wr_code (a_code_la),
        .i_wr_len  (a_len_c),
        .o_rd_code (tbl_code),
        .o_rd_len  (tbl_len)
    );

    // ------------------------------------------------------------------- pack
    always_comb begin
        b_room      = !r_out_vld || !i_out_stall;
        b_len_eff   = r_b_inr ? tbl_len : '0;
        b_is_flush  = r_b_cmd == htbp_pkg::CMD_FLUSH;
        b_is_enc    = (r_b_cmd == htbp_pkg::CMD_ENCODE) && (b_len_eff != '0);
        b_t         = TW'(r_cnt) + TW'(b_len_eff);
        b_n         = IW'(b_t >> 3);
        b_emit_enc  = b_is_enc && (b_n != '0);
        // pending bits on top, code right behind them
        b_win       = {r_pend, {(WW-8){1'b0}}}
                    | ({tbl_code, {(WW-MAX_CODE_LEN){1'b0}}} >> r_cnt);
        b_last_byte = {1'b0, r_b_idx} == ((IW+1)'(NB) - {1'b0, b_n});
        b_res_idx   = IW'((IW+1)'(NB - 1) - {1'b0, b_n});
        b_emit      = r_b_vld && (b_is_flush || b_emit_enc) && b_room;

        priority if (!r_b_vld) begin
            b_done = 1'b0;
        end else if (b_is_flush) begin
            b_done = b_room;
        end else if (b_emit_enc) begin
            b_done = b_room && b_last_byte;
        end else begin
            b_done = 1'b1;
        end

        if (b_is_flush) begin
            b_res.packed_byte = r_pend;
            b_res.valid_bits  = {1'b0, r_cnt};
            b_res.stream_bits = r_total;
            b_res.last        = 1'b1;
        end else begin
            b_res.packed_byte = b_win[r_b_idx];
            b_res.valid_bits  = htbp_pkg::FULL_BYTE;
            b_res.stream_bits = '0;
            b_res.last        = b_last_byte;
        end

        b_sum   = {1'b0, r_total} + (XW+1)'(b_len_eff);
        n_pend  = r_pend;
        n_cnt   = r_cnt;
        n_total = r_total;
        if (b_done && b_is_flush) begin
            n_pend  = '0;
            n_cnt   = '0;
            n_total = '0;
        end else if (b_done && b_is_enc) begin
            n_pend  = b_win[b_res_idx];
            n_cnt   = b_t[2:0];
            n_total = b_sum[XW] ? '1 : b_sum[XW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_move) begin
            r_b_cmd <= r_a.command;
            r_b_inr <= a_in_range;
            r_b_idx <= IW'(NB - 1);
        end else if (b_emit) begin
            r_b_idx <= r_b_idx - IW'(1);
        end
        if (b_emit) begin
            r_out <= b_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_out_vld <= 1'b0;
            r_pend    <= '0;
            r_cnt     <= '0;
            r_total   <= '0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                r_a_vld <= 1'b1;
            end else if (a_move) begin
                r_a_vld <= 1'b0;
            end
            if (a_move) begin
                r_b_vld <= 1'b1;
            end else if (b_done) begin
                r_b_vld <= 1'b0;
            end
            if (b_emit) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            r_pend  <= n_pend;
            r_cnt   <= n_cnt;
            r_total <= n_total;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // ------------------------------------------------------------- assertions
    `HTBP_ASSERT_NOW(a_partial_is_last, i_clk, i_rst_n,
        r_out_vld && (r_out.valid_bits != htbp_pkg::FULL_BYTE), r_out.last)
    `HTBP_ASSERT_NOW(a_idx_in_range, i_clk, i_rst_n, r_b_vld && b_emit_enc,
        {1'b0, r_b_idx} >= ((IW+1)'(NB) - {1'b0, b_n}))
    `HTBP_ASSERT_NEXT(a_flush_clears, i_clk, i_rst_n, b_done && b_is_flush,
        (r_cnt == '0) && (r_total == '0) && (r_pend == '0))
    `HTBP_ASSERT_NEXT(a_total_grows, i_clk, i_rst_n, r_b_vld && !b_is_flush,
        r_total >= $past(r_total))

endmodule
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Huffman table bit packer testbench
// Loads code tables and encodes and flushes symbol streams. A behavioural
// packer predicts every output beat. The checker compares each output beat,
// field by field, with the oldest prediction. Traffic runs with and without
// input gaps and output stalls.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam logic [htbp_pkg::TOTAL_WIDTH-1:0] TOTAL_MAX = '1;
    localparam int CYCLE_LIMIT = 200000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    htbp_pkg::t_in_item  in_data = '0;
    logic                in_stall;
    logic                out_valid;
    htbp_pkg::t_out_item out_data;
    logic                out_stall = 1'b0;

    logic [63:0]                     code_tab [htbp_pkg::ALPHABET_SIZE];
    logic [6:0]                      len_tab [htbp_pkg::ALPHABET_SIZE];
    logic [6:0]                      pend_bits = '0;
    logic [2:0]                      pend_count = '0;
    logic [htbp_pkg::TOTAL_WIDTH-1:0] bit_sum = '0;
    htbp_pkg::t_out_item             bytes_due [$];
    logic [7:0]                      known_syms [$];

    int send_idle_pct = 0;
    int hold_pct = 0;
    int errors = 0;
    int items_sent = 0;
    int beats_checked = 0;
    int flushes_checked = 0;
    int cycle_count = 0;

    huffman_table_bit_packer dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .i_in_data  (in_data),
        .o_in_stall (in_stall),
        .o_out_valid(out_valid),
        .o_out_data (out_data),
        .i_out_stall(out_stall)
    );

    always #4 clk = ~clk;

    initial begin
        for (int s = 0; s < htbp_pkg::ALPHABET_SIZE; s++) begin
            len_tab[s] = '0;
        end
    end

    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < hold_pct);
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d beats outstanding", $time, bytes_due.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic advance_bitstream(input htbp_pkg::t_in_item beat);
        htbp_pkg::t_out_item held;
        logic                have_held;
        logic [6:0]          len;
        logic [7:0]          acc;
        int                  cnt;
        have_held = 1'b0;
        held = '0;
        case (beat.command)
            htbp_pkg::CMD_LOAD: begin
                code_tab[beat.symbol] = beat.code_bits;
                len_tab[beat.symbol] = (beat.code_length > htbp_pkg::MAX_CODE_LEN) ?
                                       7'(htbp_pkg::MAX_CODE_LEN) : beat.code_length;
            end
            htbp_pkg::CMD_ENCODE: begin
                len = len_tab[beat.symbol];
                acc = {1'b0, pend_bits};
                cnt = int'(pend_count);
                for (int b = int'(len) - 1; b >= 0; b--) begin
                    acc = {acc[6:0], code_tab[beat.symbol][b]};
                    cnt++;
                    if (cnt == 8) begin
                        if (have_held) begin
                            bytes_due.push_back(held);
                        end
                        held = '{packed_byte: acc, valid_bits: htbp_pkg::FULL_BYTE,
                                 stream_bits: '0, last: 1'b0};
                        have_held = 1'b1;
                        acc = '0;
                        cnt = 0;
                    end
                end
                if (have_held) begin
                    held.last = 1'b1;
                    bytes_due.push_back(held);
                end
                pend_bits = acc[6:0];
                pend_count = 3'(cnt);
                if (bit_sum > TOTAL_MAX - htbp_pkg::TOTAL_WIDTH'(len)) begin
                    bit_sum = TOTAL_MAX;
                end else begin
                    bit_sum = bit_sum + htbp_pkg::TOTAL_WIDTH'(len);
                end
            end
            htbp_pkg::CMD_FLUSH: begin
                held.packed_byte = (pend_count == 0) ? 8'h00 :
                                   8'({1'b0, pend_bits} << (4'd8 - 4'(pend_count)));
                held.valid_bits = 4'(pend_count);
                held.stream_bits = bit_sum;
                held.last = 1'b1;
                bytes_due.push_back(held);
                pend_bits = '0;
                pend_count = '0;
                bit_sum = '0;
            end
            default: begin
            end
        endcase
    endtask

    task automatic compare_field(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
            errors++;
        end
    endtask

    always @(posedge clk) begin : result_check
        htbp_pkg::t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (bytes_due.size() == 0) begin
                $display("%0t: unexpected beat, expected none actual %h", $time, out_data);
                errors++;
            end else begin
                want = bytes_due.pop_front();
                compare_field("packed_byte", 64'(want.packed_byte),
                              64'(out_data.packed_byte));
                compare_field("valid_bits", 64'(want.valid_bits),
                              64'(out_data.valid_bits));
                compare_field("stream_bits", 64'(want.stream_bits),
                              64'(out_data.stream_bits));
                compare_field("last", 64'(want.last), 64'(out_data.last));
                beats_checked++;
                if (want.valid_bits != htbp_pkg::FULL_BYTE) begin
                    flushes_checked++;
                end
            end
        end
    end

    function automatic htbp_pkg::t_in_item make_beat(input logic [1:0] cmd,
                                                     input logic [7:0] sym,
                                                     input logic [63:0] code,
                                                     input logic [6:0] len);
        htbp_pkg::t_in_item beat;
        beat.command = cmd;
        beat.symbol = sym;
        beat.code_bits = code;
        beat.code_length = len;
        return beat;
    endfunction

    // entered and left at a falling edge
    task automatic send_beat(input htbp_pkg::t_in_item beat);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= beat;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        advance_bitstream(beat);
        items_sent++;
        @(negedge clk);
    endtask

    // hold the input until every predicted beat has arrived
    task automatic settle();
        in_valid <= 1'b0;
        while (bytes_due.size() != 0) begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic test_idle_stream();
        send_idle_pct = 0;
        hold_pct = 0;
        send_beat(make_beat(htbp_pkg::CMD_FLUSH, 8'h00, '0, '0));
        send_beat(make_beat(htbp_pkg::CMD_ENCODE, 8'h3C, '0, '0));
        send_beat(make_beat(CMD_NONE, 8'hFF, '1, '1));
        send_beat(make_beat(htbp_pkg::CMD_FLUSH, 8'hFF, '1, '1));
        settle();
    endtask

    task automatic test_code_extremes();
        send_beat(make_beat(htbp_pkg::CMD_LOAD, 8'h00, 64'h1, 7'd1));
        send_beat(make_beat(htbp_pkg::CMD_LOAD, 8'hFF, '1, 7'd64));
        send_beat(make_beat(htbp_pkg::CMD_LOAD, 8'h80, 64'hFFFF_FFFF_FFFF_FF5A, 7'd8));
        send_beat(make_beat(htbp_pkg::CMD_LOAD, 8'h01, {$urandom(), $urandom()}, 7'd127));
        send_beat(make_beat(htbp_pkg::CMD_LOAD, 8'h7F, '1, 7'd0));
        send_beat(make_beat(htbp_pkg::CMD_ENCODE, 8'h00, '0, '0));
        send_beat(make_beat(htbp_pkg::CMD_ENCODE, 8'h80, '0, '0));
        send_beat(make_beat(htbp_pkg::CMD_ENCODE, 8'hFF, '0, '0));
        send_beat(make_beat(htbp_pkg::CMD_ENCODE, 8'h01, '0, '0));
        send_beat(make_beat(htbp_pkg::CMD_ENCODE, 8'h7F, '0, '0));
        send_beat(make_beat(htbp_pkg::CMD_FLUSH, 8'h00, '0, '0));
        settle();
    endtask

    task automatic test_byte_burst();
        hold_pct = 50;
        send_beat(make_beat(htbp_pkg::CMD_LOAD, 8'h55, 64'h55, 7'd7));
        send_beat(make_beat(htbp_pkg::CMD_LOAD, 8'hAA, 64'h0, 7'd64));
        send_beat(make_beat(htbp_pkg::CMD_ENCODE, 8'h55, '0, '0));
        send_beat(make_beat(htbp_pkg::CMD_ENCODE, 8'hFF, '0, '0));
        send_beat(make_beat(htbp_pkg::CMD_ENCODE, 8'hAA, '0, '0));
        send_beat(make_beat(htbp_pkg::CMD_FLUSH, 8'h00, '0, '0));
        settle();
    endtask

    task automatic test_random_traffic(input int idle, input int hold, input int count);
        htbp_pkg::t_in_item beat;
        int                 pick;
        int                 lsel;
        send_idle_pct = idle;
        hold_pct = hold;
        repeat (count) begin
            pick = $urandom_range(99);
            beat.symbol = 8'($urandom_range(255));
            beat.code_bits = {$urandom(), $urandom()};
            beat.code_length = 7'($urandom_range(127));
            if (known_syms.size() == 0 || pick < 15) begin
                beat.command = htbp_pkg::CMD_LOAD;
                lsel = $urandom_range(99);
                if (lsel < 60) begin
                    beat.code_length = 7'($urandom_range(12, 1));
                end else if (lsel < 85) begin
                    beat.code_length = 7'($urandom_range(64, 13));
                end else if (lsel < 93) begin
                    beat.code_length = 7'($urandom_range(127, 65));
                end else begin
                    beat.code_length = '0;
                end
                known_syms.push_back(beat.symbol);
            end else if (pick < 75) begin
                beat.command = htbp_pkg::CMD_ENCODE;
                beat.symbol = known_syms[$urandom_range(known_syms.size() - 1)];
            end else if (pick < 85) begin
                beat.command = htbp_pkg::CMD_FLUSH;
            end else if (pick < 93) begin
                beat.command = htbp_pkg::CMD_ENCODE;
            end else begin
                beat.command = CMD_NONE;
            end
            send_beat(beat);
        end
        send_beat(make_beat(htbp_pkg::CMD_FLUSH, 8'h00, '0, '0));
        settle();
    endtask

    initial begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_idle_stream();
        test_code_extremes();
        test_byte_burst();
        test_random_traffic(0, 0, 24);
        test_random_traffic(66, 0, 24);
        test_random_traffic(0, 66, 24);
        test_random_traffic(25, 25, 24);
        repeat (16) @(posedge clk);
        $display("Sent %0d items; checked %0d output beats, %0d of them flush beats.",
                 items_sent, beats_checked, flushes_checked);
        $display("Covered table loads, overlong and empty codes, byte bursts and stalls.");
        if (errors == 0 && bytes_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
